// ===== src/pdd_pkg.sv =====
// Shared types, widths, register codes and reset values of the position dwell detector.
package pdd_pkg;

  localparam int CAM_W     = 12;   // camera coordinate width
  localparam int SW_W      = 14;   // screen size register width
  localparam int CW_W      = 13;   // camera size register width
  localparam int RAD_W     = 8;    // still radius width
  localparam int CUR_W     = 13;   // cursor output width
  localparam int CFG_W     = 14;   // configuration data width
  localparam int CFG_IDX_W = 3;    // configuration index width

  localparam int PT_W   = 15;            // mapped point, signed
  localparam int PT_MAX = 12286;         // largest mapped coordinate
  localparam int SQ_W   = 2 * PT_W - 2;  // one squared offset
  localparam int LIM_W  = 2 * (RAD_W + 1);

  localparam int WINDOW_DEF = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_RADIUS  = 3'd4;

  localparam logic [SW_W-1:0]  RST_SCREEN_WIDTH  = 14'd1920;
  localparam logic [SW_W-1:0]  RST_SCREEN_HEIGHT = 14'd1080;
  localparam logic [CW_W-1:0]  RST_CAMERA_WIDTH  = 13'd640;
  localparam logic [CW_W-1:0]  RST_CAMERA_HEIGHT = 13'd480;
  localparam logic [RAD_W-1:0] RST_STILL_RADIUS  = 8'd10;

  typedef struct packed {
    logic [SW_W-1:0]  screen_width;
    logic [SW_W-1:0]  screen_height;
    logic [CW_W-1:0]  camera_width;
    logic [CW_W-1:0]  camera_height;
    logic [RAD_W-1:0] still_radius;
  } pdd_cfg_t;

  typedef struct packed {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
  } pdd_point_t;

endpackage

// ===== src/pdd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pdd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

// ===== src/pdd_front.sv =====
// Front end: takes camera positions, maps them to screen coordinates and queues them.
module pdd_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [pdd_pkg::CAM_W-1:0]  in_cam_x,
  input  logic [pdd_pkg::CAM_W-1:0]  in_cam_y,
  input  pdd_pkg::pdd_cfg_t          cfg,
  output logic                       q_valid,
  input  logic                       q_pop,
  output pdd_pkg::pdd_point_t        q_point
);

  pdd_pkg::pdd_point_t fifo_r [2];
  pdd_pkg::pdd_point_t mapped;
  logic                wr_ptr_r;
  logic                rd_ptr_r;
  logic [1:0]          cnt_r;
  logic                push;
  logic                pop;

  // Screen half size plus position minus camera half size; the result always fits.
  assign mapped.x = pdd_pkg::PT_W'(cfg.screen_width[pdd_pkg::SW_W-1:1])
                  + pdd_pkg::PT_W'(in_cam_x)
                  - pdd_pkg::PT_W'(cfg.camera_width[pdd_pkg::CW_W-1:1]);
  assign mapped.y = pdd_pkg::PT_W'(cfg.screen_height[pdd_pkg::SW_W-1:1])
                  + pdd_pkg::PT_W'(in_cam_y)
                  - pdd_pkg::PT_W'(cfg.camera_height[pdd_pkg::CW_W-1:1]);

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid & ~in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_pop & q_valid;
  assign q_point  = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        fifo_r[wr_ptr_r] <= mapped;
        wr_ptr_r         <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== src/pdd_back.sv =====
// Back end: window store, running sums, centroid division and the radius walk.
module pdd_back #(
  parameter int WINDOW = pdd_pkg::WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  pdd_pkg::pdd_point_t        q_point,
  output logic                       q_pop,
  input  pdd_pkg::pdd_cfg_t          cfg,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_is_still,
  output logic [pdd_pkg::CUR_W-1:0]  out_cursor_x,
  output logic [pdd_pkg::CUR_W-1:0]  out_cursor_y
);

  localparam int IDXW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNTW = $clog2(WINDOW + 1);
  localparam int SUMW = $clog2(pdd_pkg::PT_MAX * WINDOW + 1) + 1;
  localparam int MAGW = SUMW - 1;
  localparam int MW   = MAGW + 1;
  localparam int PW   = MAGW + MW;
  localparam int PT_W = pdd_pkg::PT_W;
  localparam int SQ_W = pdd_pkg::SQ_W;
  localparam logic [MW-1:0] RECIP = MW'((64'd1 << MAGW) / WINDOW);

  typedef enum logic [2:0] {
    S_IDLE, S_UPD, S_DIV1, S_DIV2, S_DIV3, S_CHK, S_OUT
  } st_t;

  st_t                      state_r, state_nxt;
  logic [IDXW-1:0]          slot_r, slot_nxt;
  logic [CNTW-1:0]          seen_r, seen_nxt;
  pdd_pkg::pdd_point_t      pt_r, pt_nxt;
  logic signed [SUMW-1:0]   sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt;
  logic                     negx_r, negx_nxt, negy_r, negy_nxt;
  logic [MAGW-1:0]          magx_r, magx_nxt, magy_r, magy_nxt;
  logic [PW-1:0]            prodx_r, prodx_nxt, prody_r, prody_nxt;
  logic [MAGW-1:0]          q0x_r, q0x_nxt, q0y_r, q0y_nxt;
  logic [MAGW-1:0]          qwx_r, qwx_nxt, qwy_r, qwy_nxt;
  logic [pdd_pkg::LIM_W-1:0] lim_r, lim_nxt;
  logic signed [PT_W-1:0]   cx_r, cx_nxt, cy_r, cy_nxt;
  logic [CNTW-1:0]          cnt_r, cnt_nxt;
  logic                     v1_r, v1_nxt, v2_r, v2_nxt;
  logic [SQ_W-1:0]          sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic                     fail_r, fail_nxt;
  logic                     still_r, still_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_is_still_r, out_is_still_nxt;
  logic [pdd_pkg::CUR_W-1:0] out_cursor_x_r, out_cursor_x_nxt;
  logic [pdd_pkg::CUR_W-1:0] out_cursor_y_r, out_cursor_y_nxt;

  logic                     ram_we;
  logic [IDXW-1:0]          ram_raddr;
  logic [2*PT_W-1:0]        ram_rdata;
  logic signed [PT_W-1:0]   rd_x, rd_y;
  logic signed [PT_W-1:0]   old_x, old_y;
  logic signed [PT_W:0]     dx, dy;
  logic signed [2*PT_W+1:0] sqx_full, sqy_full;
  logic [SQ_W:0]            sq_sum;
  logic [MAGW-1:0]          q0x, q0y, remx, remy, qx, qy;
  logic signed [PT_W-1:0]   cx_mag, cy_mag;
  logic [pdd_pkg::RAD_W:0]  rad1;
  logic                     full;

  pdd_ram #(
    .WIDTH (2 * PT_W),
    .DEPTH (WINDOW)
  ) u_window (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (slot_r),
    .wdata   ({pt_r.x, pt_r.y}),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  assign rd_x  = ram_rdata[2*PT_W-1:PT_W];
  assign rd_y  = ram_rdata[PT_W-1:0];
  assign full  = (seen_r == CNTW'(WINDOW));
  assign old_x = full ? rd_x : '0;
  assign old_y = full ? rd_y : '0;

  assign dx       = {rd_x[PT_W-1], rd_x} - {cx_r[PT_W-1], cx_r};
  assign dy       = {rd_y[PT_W-1], rd_y} - {cy_r[PT_W-1], cy_r};
  assign sqx_full = dx * dx;
  assign sqy_full = dy * dy;
  assign sq_sum   = (SQ_W + 1)'(sqx_r) + (SQ_W + 1)'(sqy_r);

  assign q0x    = prodx_r[MAGW +: MAGW];
  assign q0y    = prody_r[MAGW +: MAGW];
  assign remx   = magx_r - qwx_r;
  assign remy   = magy_r - qwy_r;
  assign qx     = q0x_r + MAGW'(remx >= MAGW'(WINDOW));
  assign qy     = q0y_r + MAGW'(remy >= MAGW'(WINDOW));
  assign cx_mag = PT_W'(qx);
  assign cy_mag = PT_W'(qy);
  assign rad1   = {1'b0, cfg.still_radius} + (pdd_pkg::RAD_W + 1)'(1);

  assign out_valid    = out_valid_r;
  assign out_is_still = out_is_still_r;
  assign out_cursor_x = out_cursor_x_r;
  assign out_cursor_y = out_cursor_y_r;

  always_comb begin
    state_nxt        = state_r;
    slot_nxt         = slot_r;
    seen_nxt         = seen_r;
    pt_nxt           = pt_r;
    sum_x_nxt        = sum_x_r;
    sum_y_nxt        = sum_y_r;
    negx_nxt         = negx_r;
    negy_nxt         = negy_r;
    magx_nxt         = magx_r;
    magy_nxt         = magy_r;
    prodx_nxt        = prodx_r;
    prody_nxt        = prody_r;
    q0x_nxt          = q0x_r;
    q0y_nxt          = q0y_r;
    qwx_nxt          = qwx_r;
    qwy_nxt          = qwy_r;
    lim_nxt          = lim_r;
    cx_nxt           = cx_r;
    cy_nxt           = cy_r;
    cnt_nxt          = cnt_r;
    v1_nxt           = 1'b0;
    v2_nxt           = v1_r;
    sqx_nxt          = sqx_r;
    sqy_nxt          = sqy_r;
    fail_nxt         = fail_r;
    still_nxt        = still_r;
    out_valid_nxt    = out_valid_r & out_stall;
    out_is_still_nxt = out_is_still_r;
    out_cursor_x_nxt = out_cursor_x_r;
    out_cursor_y_nxt = out_cursor_y_r;
    q_pop            = 1'b0;
    ram_we           = 1'b0;
    ram_raddr        = slot_r;

    if (v1_r) begin
      sqx_nxt = sqx_full[SQ_W-1:0];
      sqy_nxt = sqy_full[SQ_W-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        // Read the slot about to be overwritten so its point can leave the sums.
        if (q_valid) begin
          q_pop     = 1'b1;
          pt_nxt    = q_point;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        ram_we    = 1'b1;
        sum_x_nxt = sum_x_r + SUMW'(pt_r.x) - SUMW'(old_x);
        sum_y_nxt = sum_y_r + SUMW'(pt_r.y) - SUMW'(old_y);
        slot_nxt  = (slot_r == IDXW'(WINDOW - 1)) ? '0 : slot_r + IDXW'(1);
        if (!full) begin
          seen_nxt = seen_r + CNTW'(1);
        end
        if (full || (seen_r == CNTW'(WINDOW - 1))) begin
          state_nxt = S_DIV1;
        end else begin
          still_nxt = 1'b0;
          state_nxt = S_OUT;
        end
      end
      S_DIV1: begin
        negx_nxt  = sum_x_r[SUMW-1];
        negy_nxt  = sum_y_r[SUMW-1];
        magx_nxt  = sum_x_r[SUMW-1] ? MAGW'(-sum_x_r) : MAGW'(sum_x_r);
        magy_nxt  = sum_y_r[SUMW-1] ? MAGW'(-sum_y_r) : MAGW'(sum_y_r);
        prodx_nxt = PW'(magx_nxt) * PW'(RECIP);
        prody_nxt = PW'(magy_nxt) * PW'(RECIP);
        lim_nxt   = rad1 * rad1;
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        // Reciprocal estimate is at most one short; the remainder fixes it next.
        q0x_nxt   = q0x;
        q0y_nxt   = q0y;
        qwx_nxt   = MAGW'(q0x * MAGW'(WINDOW));
        qwy_nxt   = MAGW'(q0y * MAGW'(WINDOW));
        state_nxt = S_DIV3;
      end
      S_DIV3: begin
        cx_nxt    = negx_r ? -cx_mag : cx_mag;
        cy_nxt    = negy_r ? -cy_mag : cy_mag;
        cnt_nxt   = '0;
        fail_nxt  = 1'b0;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        ram_raddr = cnt_r[IDXW-1:0];
        if (cnt_r != CNTW'(WINDOW)) begin
          v1_nxt  = 1'b1;
          cnt_nxt = cnt_r + CNTW'(1);
        end
        if (v2_r && (sq_sum >= (SQ_W + 1)'(lim_r))) begin
          fail_nxt = 1'b1;
        end
        if ((cnt_r == CNTW'(WINDOW)) && !v1_r && !v2_r) begin
          still_nxt = ~fail_r;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt    = 1'b1;
          out_is_still_nxt = still_r;
          out_cursor_x_nxt = still_r ? cfg.screen_width[pdd_pkg::SW_W-1:1] : '0;
          out_cursor_y_nxt = still_r ? cfg.screen_height[pdd_pkg::SW_W-1:1] : '0;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      seen_r      <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      cnt_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      fail_r      <= 1'b0;
      still_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      slot_r         <= slot_nxt;
      seen_r         <= seen_nxt;
      pt_r           <= pt_nxt;
      sum_x_r        <= sum_x_nxt;
      sum_y_r        <= sum_y_nxt;
      negx_r         <= negx_nxt;
      negy_r         <= negy_nxt;
      magx_r         <= magx_nxt;
      magy_r         <= magy_nxt;
      prodx_r        <= prodx_nxt;
      prody_r        <= prody_nxt;
      q0x_r          <= q0x_nxt;
      q0y_r          <= q0y_nxt;
      qwx_r          <= qwx_nxt;
      qwy_r          <= qwy_nxt;
      lim_r          <= lim_nxt;
      cx_r           <= cx_nxt;
      cy_r           <= cy_nxt;
      cnt_r          <= cnt_nxt;
      v1_r           <= v1_nxt;
      v2_r           <= v2_nxt;
      sqx_r          <= sqx_nxt;
      sqy_r          <= sqy_nxt;
      fail_r         <= fail_nxt;
      still_r        <= still_nxt;
      out_valid_r    <= out_valid_nxt;
      out_is_still_r <= out_is_still_nxt;
      out_cursor_x_r <= out_cursor_x_nxt;
      out_cursor_y_r <= out_cursor_y_nxt;
    end
  end

endmodule

// ===== src/position_dwell_detector.sv =====
// Top level of the position dwell detector: configuration registers, front end and back end.
//
// The detector takes one tracked camera position per item, maps it onto the screen
// (half the screen size plus the position minus half the camera size) and keeps the
// last WINDOW mapped points in a small RAM. Every item gives exactly one result item.
// Until WINDOW points have been seen the result is "not still" with a zero cursor.
// After that the centroid of the window is formed (truncating toward zero), and the
// result is still when every stored point has a squared distance to the centroid
// below (still_radius + 1) squared; a still result carries the screen centre as the
// cursor position, otherwise the cursor is zero. Items first pass a two-entry queue,
// so the input keeps accepting while the back end works, until both entries are full.
// An item that fills or refreshes a full window passes through the update, the division
// states S_DIV1 to S_DIV3, the walk that reads the stored points one per cycle through
// the single read port of the window RAM, and the output state; a filling window skips
// the division and the walk. No clearing pass is needed after reset.
// Configuration is written through cfg_we, cfg_index and cfg_data, and should only be
// changed while no item is in flight; writes to unknown indices are ignored.
module position_dwell_detector #(
  parameter int WINDOW = pdd_pkg::WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pdd_pkg::CAM_W-1:0]      in_cam_x,
  input  logic [pdd_pkg::CAM_W-1:0]      in_cam_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_is_still,
  output logic [pdd_pkg::CUR_W-1:0]      out_cursor_x,
  output logic [pdd_pkg::CUR_W-1:0]      out_cursor_y,
  input  logic                           cfg_we,
  input  logic [pdd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdd_pkg::CFG_W-1:0]      cfg_data
);

  pdd_pkg::pdd_cfg_t   cfg_r;
  pdd_pkg::pdd_point_t q_point;
  logic                q_valid;
  logic                q_pop;

  // Configuration registers; each write keeps the low bits that the register holds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= pdd_pkg::RST_SCREEN_WIDTH;
      cfg_r.screen_height <= pdd_pkg::RST_SCREEN_HEIGHT;
      cfg_r.camera_width  <= pdd_pkg::RST_CAMERA_WIDTH;
      cfg_r.camera_height <= pdd_pkg::RST_CAMERA_HEIGHT;
      cfg_r.still_radius  <= pdd_pkg::RST_STILL_RADIUS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pdd_pkg::REG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_data[pdd_pkg::SW_W-1:0];
        pdd_pkg::REG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_data[pdd_pkg::SW_W-1:0];
        pdd_pkg::REG_CAMERA_WIDTH:  cfg_r.camera_width  <= cfg_data[pdd_pkg::CW_W-1:0];
        pdd_pkg::REG_CAMERA_HEIGHT: cfg_r.camera_height <= cfg_data[pdd_pkg::CW_W-1:0];
        pdd_pkg::REG_STILL_RADIUS:  cfg_r.still_radius  <= cfg_data[pdd_pkg::RAD_W-1:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  // The front end maps positions and queues them for the back end.
  pdd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_cam_x (in_cam_x),
    .in_cam_y (in_cam_y),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_point  (q_point)
  );

  // The back end keeps the window, forms the centroid and walks the points.
  pdd_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_point      (q_point),
    .q_pop        (q_pop),
    .cfg          (cfg_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_is_still (out_is_still),
    .out_cursor_x (out_cursor_x),
    .out_cursor_y (out_cursor_y)
  );

endmodule
